// ===== sv/kehtd_pkg.sv =====
// Shared types, constants and helpers for the key edge history tap detector.
// No dependencies; the design, checker and testbench files import this package.
package kehtd_pkg;

    localparam int HISTORY_DEPTH = 8;
    localparam int KEY_COUNT     = 4;

    localparam int PTR_W     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W     = $clog2(HISTORY_DEPTH + 1);
    localparam int KEY_IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int KEY_OUT   = (KEY_COUNT < 4) ? KEY_COUNT : 4;

    typedef logic [PTR_W-1:0]     ptr_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [KEY_IDX_W-1:0] key_idx_t;

    // Classified key state codes.
    typedef enum logic [1:0] {
        KS_NONE     = 2'd0,
        KS_HELD     = 2'd1,
        KS_RELEASED = 2'd2,
        KS_PRESSED  = 2'd3
    } key_state_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_FINISH
    } fsm_state_t;

    // Request action codes.
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic sample;       // classify levels and load the sample result
        logic query_start;  // capture the query and set up the scan
        logic step;         // scan one history entry
        logic query_out;    // load the query result
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
    } dp_sts_t;

    function automatic key_state_t classify(input logic now_lvl, input logic prev_lvl);
        if (now_lvl == prev_lvl)
            return now_lvl ? KS_HELD : KS_NONE;
        return now_lvl ? KS_PRESSED : KS_RELEASED;
    endfunction

    function automatic ptr_t ptr_inc(input ptr_t p);
        return (int'(p) >= HISTORY_DEPTH - 1) ? '0 : ptr_t'(int'(p) + 1);
    endfunction

    function automatic ptr_t ptr_dec(input ptr_t p);
        return (p == '0) ? ptr_t'(HISTORY_DEPTH - 1) : ptr_t'(int'(p) - 1);
    endfunction

endpackage

// ===== sv/kehtd_req_if.sv =====
// Request channel of the key edge history tap detector: valid/ready plus payload.
// No dependencies.
interface kehtd_req_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [3:0] key_levels;
    logic [1:0] query_key;
    logic [7:0] window_length;

    modport source (output valid, action, key_levels, query_key, window_length,
                    input ready);
    modport sink   (input valid, action, key_levels, query_key, window_length,
                    output ready);
endinterface

// ===== sv/kehtd_res_if.sv =====
// Result channel of the key edge history tap detector: valid/ready plus payload.
// No dependencies.
interface kehtd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_states;
    logic       tap_found;

    modport source (output valid, key_states, tap_found, input ready);
    modport sink   (input valid, key_states, tap_found, output ready);
endinterface

// ===== sv/key_edge_history_tap_detect.sv =====
// Top level of the key edge history tap detector.
// Depends on kehtd_pkg, kehtd_req_if, kehtd_res_if, kehtd_ctrl and kehtd_dp.
//
// Usage:
// Requests arrive on the request channel (valid/ready). A request with
// action = 0 samples the four key levels; each key is classified as none,
// held, released or pressed against its previous level, and a changed state
// is appended to that key's history ring of HISTORY_DEPTH entries. A request
// with action = 1 asks whether key query_key shows a tap (a press followed by
// a release) within its newest min(window_length, HISTORY_DEPTH) entries.
// Every request yields exactly one result on the result channel: key_states
// for a sample (tap_found 0), tap_found for a query (key_states 0).
// Sample and query flow: a sample is classified in the cycle it is accepted
// and its result is valid the next cycle, so samples can stream one per cycle
// while results are taken. A query walks the history ring one entry per cycle
// through a single read port, and the request channel stays not ready while
// it scans and until its result is loaded into the output register.
// Reset: all keys read as up, every history entry is none, all write
// pointers are zero and no result is pending.
// Stall: a result holds in the output register while the receiver is not
// ready; a new request is accepted only once that register is free or is
// being emptied in the same cycle.
module key_edge_history_tap_detect
    import kehtd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    kehtd_req_if.sink    request,
    kehtd_res_if.source  result
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // The controller sequences each request; the datapath holds the key history, scan and result state.
    kehtd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (request.valid),
        .req_action (request.action),
        .req_ready  (request.ready),
        .res_valid  (result.valid),
        .res_ready  (result.ready),
        .cmd        (cmd),
        .sts        (sts)
    );

    kehtd_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .key_levels    (request.key_levels),
        .query_key     (request.query_key),
        .window_length (request.window_length),
        .key_states    (result.key_states),
        .tap_found     (result.tap_found)
    );

endmodule

// ===== sv/kehtd_ctrl.sv =====
// Controller state machine of the key edge history tap detector.
// Depends on kehtd_pkg.
module kehtd_ctrl
    import kehtd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_action,
    output logic     req_ready,
    output logic     res_valid,
    input  logic     res_ready,
    output dp_cmd_t  cmd,
    input  dp_sts_t  sts
);

    fsm_state_t state_reg, state_next;
    logic       res_valid_reg, res_valid_next;
    logic       out_free;

    assign out_free  = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        req_ready      = 1'b0;
        res_valid_next = res_valid_reg && !res_ready;
        unique case (state_reg)
            FSM_IDLE:
            begin
                req_ready = out_free;
                if (req_valid && out_free)
                begin
                    if (req_action == ACT_SAMPLE)
                    begin
                        cmd.sample     = 1'b1;
                        res_valid_next = 1'b1;
                    end
                    else
                    begin
                        cmd.query_start = 1'b1;
                        state_next      = FSM_SCAN;
                    end
                end
            end
            FSM_SCAN:
            begin
                if (sts.scan_done)
                    state_next = FSM_FINISH;
                else
                    cmd.step = 1'b1;
            end
            FSM_FINISH:
            begin
                if (out_free)
                begin
                    cmd.query_out  = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/kehtd_dp.sv =====
// Datapath of the key edge history tap detector: levels, history rings,
// write pointers, scan registers and the result register. Depends on kehtd_pkg.
module kehtd_dp
    import kehtd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    output dp_sts_t    sts,
    input  logic [3:0] key_levels,
    input  logic [1:0] query_key,
    input  logic [7:0] window_length,
    output logic [7:0] key_states,
    output logic       tap_found
);

    logic       [KEY_COUNT-1:0] last_levels_reg;
    key_state_t                 hist_reg   [KEY_COUNT][HISTORY_DEPTH];
    key_state_t                 newest_reg [KEY_COUNT];
    ptr_t                       ptr_reg    [KEY_COUNT];

    key_idx_t qkey_reg;
    ptr_t     pos_reg;
    cnt_t     rem_reg;
    logic     seen_rel_reg;
    logic     seen_press_reg;

    logic [7:0] key_states_reg;
    logic       tap_found_reg;

    // Per-key classification for a sample.
    logic       [KEY_COUNT-1:0] now_lvl;
    key_state_t                 new_st  [KEY_COUNT];
    logic       [KEY_COUNT-1:0] changed;
    ptr_t                       ptr_adv [KEY_COUNT];
    logic [7:0]                 states_packed;

    always_comb
    begin
        states_packed = '0;
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            now_lvl[k] = (k < 4) ? key_levels[k[1:0]] : 1'b0;
            new_st[k]  = classify(now_lvl[k], last_levels_reg[k]);
            changed[k] = (new_st[k] != newest_reg[k]);
            ptr_adv[k] = ptr_inc(ptr_reg[k]);
        end
        for (int k = 0; k < KEY_OUT; k++)
            states_packed[2*k +: 2] = new_st[k];
    end

    // Query setup.
    logic       key_ok;
    key_idx_t   key_ext;
    cnt_t       win_cnt;

    assign key_ok  = (int'(query_key) < KEY_COUNT);
    assign key_ext = key_idx_t'(query_key);
    assign win_cnt = (int'(window_length) > HISTORY_DEPTH) ? cnt_t'(HISTORY_DEPTH)
                                                         : cnt_t'(window_length);

    // One scan step: newest entry first, walking backwards.
    key_state_t scan_st;
    logic       seen_rel_next;
    logic       seen_press_next;

    assign scan_st         = hist_reg[qkey_reg][pos_reg];
    assign seen_rel_next   = seen_rel_reg || (scan_st == KS_RELEASED);
    assign seen_press_next = seen_press_reg || (seen_rel_next && scan_st == KS_PRESSED);

    assign sts.scan_done = (rem_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_levels_reg <= '0;
            for (int k = 0; k < KEY_COUNT; k++)
            begin
                ptr_reg[k]    <= '0;
                newest_reg[k] <= KS_NONE;
                for (int d = 0; d < HISTORY_DEPTH; d++)
                    hist_reg[k][d] <= KS_NONE;
            end
            rem_reg <= '0;
        end
        else
        begin
            if (cmd.sample)
            begin
                last_levels_reg <= now_lvl;
                for (int k = 0; k < KEY_COUNT; k++)
                begin
                    if (changed[k])
                    begin
                        ptr_reg[k]              <= ptr_adv[k];
                        newest_reg[k]           <= new_st[k];
                        hist_reg[k][ptr_adv[k]] <= new_st[k];
                    end
                end
            end
            if (cmd.query_start)
                rem_reg <= key_ok ? win_cnt : '0;
            else if (cmd.step)
                rem_reg <= rem_reg - 1'b1;
        end
    end

    // Scan and result payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.query_start)
        begin
            qkey_reg       <= key_ok ? key_ext : '0;
            pos_reg        <= key_ok ? ptr_reg[key_ext] : '0;
            seen_rel_reg   <= 1'b0;
            seen_press_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            pos_reg        <= ptr_dec(pos_reg);
            seen_rel_reg   <= seen_rel_next;
            seen_press_reg <= seen_press_next;
        end

        if (cmd.sample)
        begin
            key_states_reg <= states_packed;
            tap_found_reg  <= 1'b0;
        end
        else if (cmd.query_out)
        begin
            key_states_reg <= '0;
            tap_found_reg  <= seen_rel_reg && seen_press_reg;
        end
    end

    assign key_states = key_states_reg;
    assign tap_found  = tap_found_reg;

endmodule

// ===== sv/kehtd_checker.sv =====
// Port-level checker for the key edge history tap detector, bound to the top.
// Depends on kehtd_pkg and the top level key_edge_history_tap_detect.
module kehtd_checker
    import kehtd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       req_action,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] key_states,
    input logic       tap_found
);

    // A waiting result is held until taken.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(key_states) && $stable(tap_found))
        else $error("result changed while stalled");

    // A sample request produces its result in the next cycle.
    a_sample_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_action == ACT_SAMPLE |=> res_valid)
        else $error("sample result not presented");

    // A query blocks new requests while it scans.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_action == ACT_QUERY |=> !req_ready)
        else $error("request accepted during a scan");

    // A result carries either key states or a tap flag, never both.
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && tap_found |-> key_states == '0)
        else $error("tap reported with key states");

endmodule

bind key_edge_history_tap_detect kehtd_checker u_kehtd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (request.valid),
    .req_ready  (request.ready),
    .req_action (request.action),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .key_states (result.key_states),
    .tap_found  (result.tap_found)
);

// ===== test/tb_top.sv =====
// Self-checking testbench for key_edge_history_tap_detect: directed table, then random requests.
// Depends on kehtd_pkg, kehtd_req_if, kehtd_res_if and the key_edge_history_tap_detect RTL.
module tb_top;
    import kehtd_pkg::*;

    localparam int RANDOM_REQUESTS = 400;
    localparam int CALM_FROM       = 340;   // requests from here on run without idling
    localparam int WATCHDOG_LIMIT  = 400;
    localparam int DRAIN_CYCLES    = HISTORY_DEPTH + 8;

    typedef struct packed {
        logic       action;
        logic [3:0] key_levels;
        logic [1:0] query_key;
        logic [7:0] window_length;
    } key_request_t;

    typedef struct packed {
        logic [7:0] key_states;
        logic       tap_found;
    } key_result_t;

    // One row of the directed table. When typed is set, want is the result
    // read straight off the behavior; otherwise the predictor supplies it.
    typedef struct packed {
        key_request_t item;
        logic         typed;
        key_result_t  want;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n;

    kehtd_req_if req_bus();
    kehtd_res_if res_bus();

    key_edge_history_tap_detect dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_bus),
        .result  (res_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state: previous level, history ring and write index per key.
    logic        prev_level   [KEY_COUNT];
    key_state_t  edge_history [KEY_COUNT][HISTORY_DEPTH];
    int unsigned write_index  [KEY_COUNT];

    key_result_t   pending_results[$];
    directed_row_t directed_rows[$];
    int            errors  = 0;
    bit            idle_on = 1'b1;

    // Works out the result of one accepted request and advances the
    // predictor state the same way the block does.
    function automatic key_result_t track_keys(input key_request_t it);
        key_result_t r;
        key_state_t  st;
        logic        lvl;
        int unsigned span;
        int unsigned pos;
        int unsigned k;
        bit          saw_release;
        bit          saw_press;
        r = '0;
        if (it.action == ACT_QUERY) begin
            k = 32'(it.query_key);
            saw_release = 1'b0;
            saw_press   = 1'b0;
            if (k < KEY_COUNT) begin
                span = (it.window_length > HISTORY_DEPTH) ? HISTORY_DEPTH
                                                          : 32'(it.window_length);
                // Newest entry first, walking backwards around the ring.
                for (int i = 0; i < span; i++) begin
                    pos = (write_index[k] + HISTORY_DEPTH - i) % HISTORY_DEPTH;
                    if (edge_history[k][pos] == KS_RELEASED)
                        saw_release = 1'b1;
                    if (saw_release && edge_history[k][pos] == KS_PRESSED)
                        saw_press = 1'b1;
                end
            end
            r.tap_found = saw_release && saw_press;
        end else begin
            for (int unsigned j = 0; j < KEY_COUNT; j++) begin
                lvl = (j < 4) ? it.key_levels[j] : 1'b0;
                if (lvl == prev_level[j])
                    st = lvl ? KS_HELD : KS_NONE;
                else
                    st = lvl ? KS_PRESSED : KS_RELEASED;
                prev_level[j] = lvl;
                // Only a change of state is appended to the ring.
                if (st != edge_history[j][write_index[j]]) begin
                    write_index[j] = (write_index[j] >= HISTORY_DEPTH - 1) ? 0 : write_index[j] + 1;
                    edge_history[j][write_index[j]] = st;
                end
                if (j < 4)
                    r.key_states[2*j +: 2] = st;
            end
        end
        return r;
    endfunction

    task automatic add_row(input logic act, input logic [3:0] lv, input logic [1:0] key,
                           input logic [7:0] win, input logic typed,
                           input logic [7:0] states, input logic tap);
        directed_row_t row;
        row.item  = '{action: act, key_levels: lv, query_key: key, window_length: win};
        row.typed = typed;
        row.want  = '{key_states: states, tap_found: tap};
        directed_rows.push_back(row);
    endtask

    // Presents one request from a falling edge, holds it until accepted,
    // records the expected result and returns at the next falling edge.
    task automatic send_request(input key_request_t it, input logic typed,
                                input key_result_t want);
        int          gap;
        key_result_t predicted;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_bus.action        <= it.action;
        req_bus.key_levels    <= it.key_levels;
        req_bus.query_key     <= it.query_key;
        req_bus.window_length <= it.window_length;
        req_bus.valid         <= 1'b1;
        do
            @(posedge clk);
        while (!req_bus.ready);
        predicted = track_keys(it);
        pending_results.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // Result side: random stall bursts of ready held low while idling is on.
    initial
    begin : result_stall
        int stall_left;
        stall_left = 0;
        res_bus.ready <= 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                res_bus.ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                res_bus.ready <= 1'b0;
                stall_left = $urandom_range(1, 4) - 1;
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    // Every accepted result is compared with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        key_result_t want;
        if (rst_n && res_bus.valid && res_bus.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result key_states=%h tap_found=%b",
                         $time, res_bus.key_states, res_bus.tap_found);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (res_bus.key_states !== want.key_states) begin
                    $display("%0t: key_states expected %h, got %h",
                             $time, want.key_states, res_bus.key_states);
                    errors++;
                end
                if (res_bus.tap_found !== want.tap_found) begin
                    $display("%0t: tap_found expected %b, got %b",
                             $time, want.tap_found, res_bus.tap_found);
                    errors++;
                end
            end
        end
    end

    // The run ends if no request or result is accepted for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("key_edge_history_tap_detect verification failed");
        $finish;
    end

    initial
    begin : stimulus
        key_request_t it;
        logic [3:0]   last_levels_sent;
        for (int k = 0; k < KEY_COUNT; k++) begin
            prev_level[k]  = 1'b0;
            write_index[k] = 0;
            for (int d = 0; d < HISTORY_DEPTH; d++)
                edge_history[k][d] = KS_NONE;
        end
        rst_n = 1'b0;
        req_bus.valid         <= 1'b0;
        req_bus.action        <= ACT_SAMPLE;
        req_bus.key_levels    <= '0;
        req_bus.query_key     <= '0;
        req_bus.window_length <= '0;

        // Directed part. Straight after reset every ring holds only none, so
        // no query can find a tap; a full press, hold, release then leaves a
        // tap visible once the window reaches back to the press.
        add_row(ACT_QUERY,  4'h0, 2'd0, 8'd255, 1'b1, '0, 1'b0);
        add_row(ACT_QUERY,  4'h0, 2'd3, 8'd0,   1'b1, '0, 1'b0);
        add_row(ACT_SAMPLE, 4'h0, 2'd0, 8'd0,   1'b1, {KS_NONE, KS_NONE, KS_NONE, KS_NONE}, 1'b0);
        add_row(ACT_SAMPLE, 4'hF, 2'd0, 8'd0,   1'b1,
                {KS_PRESSED, KS_PRESSED, KS_PRESSED, KS_PRESSED}, 1'b0);
        add_row(ACT_SAMPLE, 4'hF, 2'd0, 8'd0,   1'b1, {KS_HELD, KS_HELD, KS_HELD, KS_HELD}, 1'b0);
        add_row(ACT_SAMPLE, 4'h0, 2'd0, 8'd0,   1'b1,
                {KS_RELEASED, KS_RELEASED, KS_RELEASED, KS_RELEASED}, 1'b0);
        add_row(ACT_QUERY,  4'h0, 2'd0, 8'd8,   1'b1, '0, 1'b1);
        add_row(ACT_QUERY,  4'h0, 2'd0, 8'd1,   1'b1, '0, 1'b0);
        add_row(ACT_QUERY,  4'h0, 2'd1, 8'd0,   1'b1, '0, 1'b0);
        add_row(ACT_QUERY,  4'h0, 2'd2, 8'd255, 1'b1, '0, 1'b1);
        add_row(ACT_QUERY,  4'h0, 2'd3, 8'd2,   1'b0, '0, 1'b0);
        add_row(ACT_QUERY,  4'h0, 2'd3, 8'd3,   1'b0, '0, 1'b0);
        add_row(ACT_SAMPLE, 4'h5, 2'd0, 8'd0,   1'b0, '0, 1'b0);
        add_row(ACT_SAMPLE, 4'hA, 2'd0, 8'd0,   1'b0, '0, 1'b0);
        add_row(ACT_SAMPLE, 4'h5, 2'd0, 8'd0,   1'b0, '0, 1'b0);
        add_row(ACT_QUERY,  4'h0, 2'd1, 8'd3,   1'b0, '0, 1'b0);
        // Toggle all keys enough times to wrap every write pointer.
        for (int n = 0; n < 5; n++) begin
            add_row(ACT_SAMPLE, 4'hF, 2'd0, 8'd0, 1'b0, '0, 1'b0);
            add_row(ACT_SAMPLE, 4'h0, 2'd0, 8'd0, 1'b0, '0, 1'b0);
        end
        add_row(ACT_QUERY,  4'h0, 2'd1, 8'd9,   1'b0, '0, 1'b0);
        add_row(ACT_QUERY,  4'h0, 2'd3, 8'd128, 1'b0, '0, 1'b0);

        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

        // Random part. Levels repeat often so that held and unchanged states
        // occur; windows stay mostly near the ring depth, with the full range
        // now and then.
        last_levels_sent = '0;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            idle_on = !((n >= 150 && n < 190) || n >= CALM_FROM);
            it = '0;
            if ($urandom_range(0, 9) < 3) begin
                it.action    = ACT_QUERY;
                it.query_key = 2'($urandom_range(0, 3));
                if ($urandom_range(0, 7) == 0)
                    it.window_length = 8'($urandom_range(0, 255));
                else
                    it.window_length = 8'($urandom_range(0, HISTORY_DEPTH + 1));
                it.key_levels = 4'($urandom_range(0, 15));
            end else begin
                it.action = ACT_SAMPLE;
                if ($urandom_range(0, 2) == 0)
                    it.key_levels = last_levels_sent;
                else
                    it.key_levels = 4'($urandom_range(0, 15));
                last_levels_sent = it.key_levels;
                it.query_key     = 2'($urandom_range(0, 3));
                it.window_length = 8'($urandom_range(0, 255));
            end
            send_request(it, 1'b0, '0);
        end
        req_bus.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && pending_results.size() == 0)
            $display("key_edge_history_tap_detect verification clean");
        else
            $display("key_edge_history_tap_detect verification failed");
        $finish;
    end

endmodule
